// ===== rtl/tcb_pkg.sv =====
// Shared types and constants for the text console screen buffer.
package tcb_pkg;

    // Terminal control bytes
    localparam logic [7:0] BYTE_BACKSPACE = 8'h7F;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic [2:0] read_row;
        logic [4:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [2:0] cursor_row;
        logic [4:0] cursor_col;
        logic       scrolled;
    } t_out_item;

endpackage

// ===== rtl/tcb_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module tcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 168
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/text_console_buffer.sv =====
// Top level of the text console screen buffer.
//
// Character-cell terminal screen of SCREEN_ROWS x SCREEN_COLS cells held in
// one single-port RAM, with a cursor and a top-row pointer so that a scroll
// moves the pointer and blanks one physical row instead of moving text.
// A write transfer (func 0) handles one terminal byte: backspace steps left
// (not past column 0) and blanks the cell under the cursor, newline goes to
// the next row and column 0, carriage return goes to column 0, anything else
// is stored at the cursor, which advances and wraps. Stepping below the last
// row scrolls. A read transfer (func 1) returns one cell; an out-of-range
// row or column reads as 0. Every item gives exactly one result transfer with
// the cursor after the item and a scroll flag.
// Timing: after reset the RAM is blanked one cell per cycle, so input is
// stalled until all SCREEN_ROWS*SCREEN_COLS cells (168 at the defaults) are
// blank. After that, an item passes S_EXEC then S_DONE, with S_READ between
// for an in-range read, which waits on the registered RAM read data; an item
// that scrolls passes S_SCRUB, one RAM write per cell of the new bottom row,
// through the single RAM port. One item is worked at a time; the next is
// taken while a result still waits in the output register.
module text_console_buffer #(
    parameter int SCREEN_ROWS = 8,
    parameter int SCREEN_COLS = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcb_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcb_pkg::t_out_item o_out
);

    import tcb_pkg::*;

    localparam int DEPTH = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,   // post-reset RAM blanking sweep
        S_IDLE  = 6'b000010,   // waiting for an input transfer
        S_EXEC  = 6'b000100,   // decode item, issue RAM access
        S_SCRUB = 6'b001000,   // blank new bottom row after a scroll
        S_READ  = 6'b010000,   // RAM read data lands
        S_DONE  = 6'b100000    // hand result to the output register
    } t_state;

    // Physical RAM address of a screen cell: the screen row is rotated by
    // the top-row pointer, then flattened row-major.
    function automatic logic [AW-1:0] f_phys(input logic [RW-1:0] top_ptr,
                                             input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
        logic [RW:0]   sum;
        logic [RW-1:0] prow;
        sum = {1'b0, top_ptr} + {1'b0, row};
        if (sum >= (RW+1)'(SCREEN_ROWS)) begin
            sum = sum - (RW+1)'(SCREEN_ROWS);
        end
        prow = sum[RW-1:0];
        return AW'(32'(prow) * SCREEN_COLS + 32'(col));
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_top, n_top;
    logic [CW-1:0]   r_scrub_col, n_scrub_col;
    t_in_item        r_item, n_item;
    logic [7:0]      r_cell, n_cell;
    logic            r_scroll, n_scroll;
    logic            r_out_valid;
    t_out_item       r_out;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;

    logic            load_out;
    logic            do_adv;
    logic [CW-1:0]   bs_col;
    logic            rd_in_range;
    logic            row_last;
    logic            col_last;
    logic [RW-1:0]   top_next;

    tcb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_in_range = (32'(r_item.read_row) < SCREEN_ROWS) &&
                         (32'(r_item.read_col) < SCREEN_COLS);
    assign row_last    = (r_row == RW'(SCREEN_ROWS - 1));
    assign col_last    = (r_col == CW'(SCREEN_COLS - 1));
    assign top_next    = (r_top == RW'(SCREEN_ROWS - 1)) ? '0 : r_top + RW'(1);
    // Backspace target: one left, but never past column 0
    assign bs_col      = (r_col != '0) ? r_col - CW'(1) : r_col;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_scrub_col = r_scrub_col;
        n_item      = r_item;
        n_cell      = r_cell;
        n_scroll    = r_scroll;
        ram_we      = 1'b0;
        ram_addr    = '0;
        ram_wdata   = '0;
        load_out    = 1'b0;
        do_adv      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cell   = '0;
                n_scroll = 1'b0;
                n_state  = S_DONE;
                if (r_item.func == FUNC_READ) begin
                    if (rd_in_range) begin
                        ram_addr = f_phys(r_top, RW'(r_item.read_row),
                                          CW'(r_item.read_col));
                        n_state  = S_READ;
                    end
                end else begin
                    case (r_item.data_byte)
                        BYTE_BACKSPACE: begin
                            ram_we   = 1'b1;
                            ram_addr = f_phys(r_top, r_row, bs_col);
                            n_col    = bs_col;
                        end
                        BYTE_NEWLINE: begin
                            n_col  = '0;
                            do_adv = 1'b1;
                        end
                        BYTE_CR: begin
                            n_col = '0;
                        end
                        default: begin
                            ram_we    = 1'b1;
                            ram_addr  = f_phys(r_top, r_row, r_col);
                            ram_wdata = r_item.data_byte;
                            if (col_last) begin
                                n_col  = '0;
                                do_adv = 1'b1;
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                    endcase
                end
                // Row advance; below the last row the screen scrolls
                if (do_adv) begin
                    if (row_last) begin
                        n_top       = top_next;
                        n_scroll    = 1'b1;
                        n_scrub_col = '0;
                        n_state     = S_SCRUB;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end
            end
            S_SCRUB: begin
                // r_top already points past the old top row
                ram_we      = 1'b1;
                ram_addr    = f_phys(r_top, RW'(SCREEN_ROWS - 1), r_scrub_col);
                n_scrub_col = r_scrub_col + CW'(1);
                if (r_scrub_col == CW'(SCREEN_COLS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_scrub_col <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_scrub_col <= n_scrub_col;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_cell   <= n_cell;
        r_scroll <= n_scroll;
        if (load_out) begin
            r_out.cell_char  <= r_cell;
            r_out.cursor_row <= 3'(r_row);
            r_out.cursor_col <= 5'(r_col);
            r_out.scrolled   <= r_scroll;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== tb/tb_text_console_buffer.sv =====
`timescale 1ns / 1ps
// Testbench for text_console_buffer: random terminal traffic checked against a screen predictor.
module tb_text_console_buffer;
    import tcb_pkg::*;

    localparam int ROWS         = 8;
    localparam int COLS         = 21;
    localparam int RANDOM_ITEMS = 400;
    // the last stretch of random items runs with both sides idle-free
    localparam int QUIET_TAIL   = 60;

    // Screen predictor plus the queue of results still owed by the block.
    // The screen is kept as a ring of physical rows with a top-row pointer,
    // so a scroll bumps the pointer and blanks the row that becomes the bottom.
    class console_scoreboard;
        logic [7:0]  cells [ROWS][COLS];
        int unsigned cur_row;
        int unsigned cur_col;
        int unsigned top_row;
        t_out_item   pending_results [$];
        int unsigned error_count;

        function new();
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    cells[r][c] = '0;
            cur_row     = 0;
            cur_col     = 0;
            top_row     = 0;
            error_count = 0;
        endfunction

        function int unsigned phys_row(int unsigned r);
            return (top_row + r) % ROWS;
        endfunction

        // Step the cursor down one row; returns 1 when the screen scrolled.
        function bit next_row();
            if (cur_row + 1 < ROWS) begin
                cur_row++;
                return 1'b0;
            end
            top_row = (top_row + 1) % ROWS;
            for (int c = 0; c < COLS; c++)
                cells[phys_row(ROWS - 1)][c] = '0;
            return 1'b1;
        endfunction

        // Apply one item to the screen and return the result it should produce.
        function t_out_item apply_item(t_in_item it);
            t_out_item res;
            res = '0;
            if (it.func == FUNC_READ) begin
                // out-of-range cells read as empty
                if (it.read_row < ROWS && it.read_col < COLS)
                    res.cell_char = cells[phys_row(it.read_row)][it.read_col];
            end else if (it.data_byte == BYTE_BACKSPACE) begin
                // at column 0 the cursor stays but the cell is still blanked
                if (cur_col > 0)
                    cur_col--;
                cells[phys_row(cur_row)][cur_col] = '0;
            end else if (it.data_byte == BYTE_NEWLINE) begin
                res.scrolled = next_row();
                cur_col = 0;
            end else if (it.data_byte == BYTE_CR) begin
                cur_col = 0;
            end else begin
                // every other byte, 0x00 included, lands at the cursor
                cells[phys_row(cur_row)][cur_col] = it.data_byte;
                cur_col++;
                if (cur_col >= COLS) begin
                    res.scrolled = next_row();
                    cur_col = 0;
                end
            end
            res.cursor_row = 3'(cur_row);
            res.cursor_col = 5'(cur_col);
            return res;
        endfunction

        function void note_transfer(t_in_item it);
            pending_results.push_back(apply_item(it));
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        task check_transfer(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.cell_char !== want.cell_char)
                report($sformatf("cell_char %h, want %h", got.cell_char, want.cell_char));
            if (got.cursor_row !== want.cursor_row)
                report($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report($sformatf("cursor_col %0d, want %0d", got.cursor_col, want.cursor_col));
            if (got.scrolled !== want.scrolled)
                report($sformatf("scrolled %b, want %b", got.scrolled, want.scrolled));
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    // idling allowed on both sides while set
    bit idle_on;

    console_scoreboard board = new();

    text_console_buffer #(
        .SCREEN_ROWS (ROWS),
        .SCREEN_COLS (COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit: well beyond a slow run (clearing pass, every item scrolling,
    // worst gaps and stalls on both sides).
    initial begin
        #200000;
        $display("tb_text_console_buffer: done, errors");
        $finish;
    end

    function automatic t_in_item make_write(logic [7:0] b);
        t_in_item it;
        it.func      = FUNC_WRITE;
        it.data_byte = b;
        // unused on writes, but keep them moving
        it.read_row  = 3'($urandom);
        it.read_col  = 5'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_read(logic [2:0] r, logic [4:0] c);
        t_in_item it;
        it.func      = FUNC_READ;
        it.data_byte = 8'($urandom);
        it.read_row  = r;
        it.read_col  = c;
        return it;
    endfunction

    // Mostly printable text so lines fill, wrap and scroll; a share of
    // control bytes, reads (a few out of range) and fully random bytes.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it   = make_write(8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            it.func = FUNC_READ;
            if ($urandom_range(0, 7) != 0)
                it.read_col = 5'($urandom_range(0, COLS - 1));
        end else if (pick < 30) begin
            it.data_byte = BYTE_NEWLINE;
        end else if (pick < 34) begin
            it.data_byte = BYTE_CR;
        end else if (pick < 40) begin
            it.data_byte = BYTE_BACKSPACE;
        end else if (pick < 88) begin
            it.data_byte = 8'($urandom_range(8'h20, 8'h7E));
        end
        return it;
    endfunction

    // One input transfer. Valid stays high from one item to the next unless
    // an idle burst drops it first, so valid gets one assignment per edge.
    task automatic send_item(input t_in_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        // stall is read before this edge's updates land, i.e. as the block saw it
        do @(posedge i_clk); while (in_stall);
        board.note_transfer(it);
    endtask

    // Result side: check each accepted transfer, then pick the stall for the
    // next edge, in bursts while idling is on.
    initial begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall)
                board.check_transfer(out_item);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int n;
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        idle_on   = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty screen, out-of-range read, backspace at column 0,
        // byte extremes, 0x00 stored as an ordinary byte, backspace mid-line,
        // carriage return, then enough newlines to scroll.
        send_item(make_read(3'd0, 5'd0));
        send_item(make_read(3'd7, 5'd31));
        send_item(make_write(BYTE_BACKSPACE));
        send_item(make_write(8'hFF));
        send_item(make_write(8'h00));
        send_item(make_write(8'h41));
        send_item(make_write(BYTE_BACKSPACE));
        send_item(make_read(3'd0, 5'd0));
        send_item(make_read(3'd0, 5'd1));
        send_item(make_read(3'd0, 5'd21));
        send_item(make_write(BYTE_CR));
        send_item(make_write(8'h5A));
        send_item(make_read(3'd0, 5'd20));
        for (n = 0; n < ROWS; n++)
            send_item(make_write(BYTE_NEWLINE));
        send_item(make_read(3'd0, 5'd0));
        send_item(make_read(3'd7, 5'd20));

        // Random: idling in stretches, with an idle-free tail.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 50) % 3 != 2);
            send_item(random_item());
        end
        in_valid <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (40) @(posedge i_clk);

        if (board.error_count == 0)
            $display("tb_text_console_buffer: done, clean");
        else
            $display("tb_text_console_buffer: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcb_pkg.sv
rtl/tcb_ram.sv
rtl/text_console_buffer.sv
tb/tb_text_console_buffer.sv
